@@ hw/rtl/cld_pkg.sv @@
// shared types, codes and constants for the content-length deframer
// no dependencies; imported by every module of the block

package cld_pkg;

    localparam int          QUEUE_DEPTH   = 2;
    localparam int          QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int          QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0]  KEY_LENGTH    = 4'd14;
    localparam logic [30:0] MAX_LEN_RST   = 31'h7FFF_FFFF;
    localparam logic [31:0] SAT_MAG       = 32'h8000_0000;

    localparam logic [7:0]  CHR_LF        = 8'h0A;
    localparam logic [7:0]  CHR_CR        = 8'h0D;
    localparam logic [7:0]  CHR_TAB       = 8'h09;
    localparam logic [7:0]  CHR_SP        = 8'h20;
    localparam logic [7:0]  CHR_COLON     = 8'h3A;
    localparam logic [7:0]  CHR_PLUS      = 8'h2B;
    localparam logic [7:0]  CHR_MINUS     = 8'h2D;
    localparam logic [7:0]  CHR_ZERO      = 8'h30;
    localparam logic [7:0]  CHR_NINE      = 8'h39;

    typedef enum logic [2:0] {
        ST_PAYLOAD = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_INVALID = 3'd2,
        ST_RANGE   = 3'd3,
        ST_MISSING = 3'd4,
        ST_TRUNC   = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        PH_LINE_START = 4'd0,
        PH_LINE_CR    = 4'd1,
        PH_KEY        = 4'd2,
        PH_WS         = 4'd3,
        PH_SIGN       = 4'd4,
        PH_DIGITS     = 4'd5,
        PH_VALUE_DONE = 4'd6,
        PH_SKIP       = 4'd7,
        PH_PAYLOAD    = 4'd8
    } t_phase;

    // classified input word handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
        logic       is_lf;
        logic       is_cr;
        logic       is_colon;
        logic       is_ws;
        logic       is_sign;
        logic       is_minus;
        logic       is_digit;
        logic [3:0] digit;
    } t_item;

    // header key text, zero beyond its end
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/cld_front.sv @@
// front stage: accepts stream words and classifies each byte
// depends on cld_pkg (t_item, character constants)

module cld_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_data,
    input  logic           i_eoi,
    output logic           o_valid,
    input  logic           i_ready,
    output cld_pkg::t_item o_item
);
    import cld_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.data     = i_data;
        n_item.eoi      = i_eoi;
        n_item.is_lf    = (i_data == CHR_LF);
        n_item.is_cr    = (i_data == CHR_CR);
        n_item.is_colon = (i_data == CHR_COLON);
        n_item.is_ws    = (i_data inside {[CHR_TAB:CHR_CR], CHR_SP});
        n_item.is_sign  = (i_data == CHR_PLUS) || (i_data == CHR_MINUS);
        n_item.is_minus = (i_data == CHR_MINUS);
        n_item.is_digit = (i_data inside {[CHR_ZERO:CHR_NINE]});
        n_item.digit    = 4'(i_data - CHR_ZERO);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

endmodule

@@ hw/rtl/cld_queue.sv @@
// short word queue between the front and back stages
// depends on cld_pkg (t_item, queue depth)

module cld_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cld_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output cld_pkg::t_item o_item
);
    import cld_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               push;
    logic               pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ hw/rtl/cld_back.sv @@
// back stage: header parser, length check, payload counter and output register
// depends on cld_pkg (t_item, t_phase, t_status, key text)

module cld_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [30:0]    i_cfg_wr_data,
    input  logic           i_valid,
    output logic           o_ready,
    input  cld_pkg::t_item i_item,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_out_byte,
    output logic [2:0]     o_out_status,
    output logic           o_out_last
);
    import cld_pkg::*;

    logic [30:0] r_max_len;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_key_pos, n_key_pos;
    logic        r_key_mis, n_key_mis;
    logic [31:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic        r_has_digit, n_has_digit;
    logic        r_found, n_found;
    logic [30:0] r_len, n_len;
    logic [30:0] r_remain, n_remain;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    t_status     r_out_status;
    logic        r_out_last;

    logic        pop;
    logic        emit;
    logic [7:0]  e_byte;
    t_status     e_status;
    logic        e_last;
    logic        do_start_line;
    logic        do_fresh;
    logic        go_payload;

    logic        in_value;
    logic        fv_err;
    t_status     fv_status;
    logic [34:0] acc_x10;
    logic [31:0] acc_digit;
    logic        key_hit;
    logic        key_done;
    logic        blk_found;
    logic [30:0] blk_len;

    assign pop = i_valid && (!r_out_valid || i_out_ready);
    assign o_ready = pop;

    assign in_value = (r_phase inside {PH_SIGN, PH_DIGITS, PH_VALUE_DONE});

    // value check at end of a key line
    always_comb begin
        if (!r_has_digit) begin
            fv_err    = 1'b1;
            fv_status = ST_INVALID;
        end else if ((r_neg && (r_acc != '0)) || (r_acc > {1'b0, r_max_len})) begin
            fv_err    = 1'b1;
            fv_status = ST_RANGE;
        end else begin
            fv_err    = 1'b0;
            fv_status = ST_PAYLOAD;
        end
    end

    // saturating decimal accumulate, acc*10 as two shifted adds
    assign acc_x10   = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + {31'd0, i_item.digit};
    assign acc_digit = r_acc[31]         ? r_acc   :
                       (|acc_x10[34:31]) ? SAT_MAG : acc_x10[31:0];

    assign key_hit  = (r_key_pos < KEY_LENGTH) && (i_item.data == key_char(r_key_pos));
    assign key_done = !r_key_mis && (r_key_pos == KEY_LENGTH);

    // length as seen at end of input, after finishing a partial value line
    assign blk_found = r_found || (in_value && !fv_err);
    assign blk_len   = (in_value && !fv_err) ? r_acc[30:0] : r_len;

    always_comb begin
        n_phase       = r_phase;
        n_key_pos     = r_key_pos;
        n_key_mis     = r_key_mis;
        n_acc         = r_acc;
        n_neg         = r_neg;
        n_has_digit   = r_has_digit;
        n_found       = r_found;
        n_len         = r_len;
        n_remain      = r_remain;
        emit          = 1'b0;
        e_byte        = '0;
        e_status      = ST_PAYLOAD;
        e_last        = 1'b0;
        do_start_line = 1'b0;
        do_fresh      = 1'b0;
        go_payload    = 1'b0;

        if (i_item.eoi) begin
            emit     = 1'b1;
            e_last   = 1'b1;
            do_fresh = 1'b1;
            if (r_phase == PH_PAYLOAD) begin
                e_status = ST_TRUNC;
            end else if (in_value && fv_err) begin
                e_status = fv_status;
            end else if (!blk_found) begin
                e_status = ST_MISSING;
            end else if (blk_len == '0) begin
                e_status = ST_EMPTY;
            end else begin
                e_status = ST_TRUNC;
            end
        end else if (r_phase == PH_PAYLOAD) begin
            emit     = 1'b1;
            e_byte   = i_item.data;
            e_last   = (r_remain[30:1] == '0);
            n_remain = r_remain - 1'b1;
            do_fresh = e_last;
        end else if (i_item.is_lf) begin
            if (r_phase == PH_LINE_START || r_phase == PH_LINE_CR) begin
                if (!r_found) begin
                    emit     = 1'b1;
                    e_status = ST_MISSING;
                    e_last   = 1'b1;
                    do_fresh = 1'b1;
                end else if (r_len == '0) begin
                    emit     = 1'b1;
                    e_status = ST_EMPTY;
                    e_last   = 1'b1;
                    do_fresh = 1'b1;
                end else begin
                    do_start_line = 1'b1;
                    go_payload    = 1'b1;
                end
            end else if (in_value && fv_err) begin
                emit     = 1'b1;
                e_status = fv_status;
                e_last   = 1'b1;
                do_fresh = 1'b1;
            end else begin
                if (in_value) begin
                    n_found = 1'b1;
                    n_len   = r_acc[30:0];
                end
                do_start_line = 1'b1;
            end
        end else begin
            case (r_phase)
                PH_LINE_START, PH_LINE_CR, PH_KEY: begin
                    if (r_phase == PH_LINE_START && i_item.is_cr) begin
                        n_key_mis = 1'b1;
                        n_phase   = PH_LINE_CR;
                    end else if (i_item.is_colon) begin
                        n_phase = key_done ? PH_WS : PH_SKIP;
                    end else begin
                        n_phase = PH_KEY;
                        if (key_hit) begin
                            n_key_pos = r_key_pos + 1'b1;
                        end else begin
                            n_key_mis = 1'b1;
                        end
                    end
                end
                PH_WS: begin
                    if (i_item.is_ws) begin
                        n_phase = PH_WS;
                    end else if (i_item.is_sign) begin
                        n_neg   = i_item.is_minus;
                        n_phase = PH_SIGN;
                    end else if (i_item.is_digit) begin
                        n_acc       = acc_digit;
                        n_has_digit = 1'b1;
                        n_phase     = PH_DIGITS;
                    end else begin
                        n_phase = PH_VALUE_DONE;
                    end
                end
                PH_SIGN, PH_DIGITS: begin
                    if (i_item.is_digit) begin
                        n_acc       = acc_digit;
                        n_has_digit = 1'b1;
                        n_phase     = PH_DIGITS;
                    end else begin
                        n_phase = PH_VALUE_DONE;
                    end
                end
                PH_VALUE_DONE, PH_SKIP: begin
                    n_phase = r_phase;
                end
                default: begin
                    do_start_line = 1'b1;
                end
            endcase
        end

        if (do_start_line || do_fresh) begin
            n_phase     = PH_LINE_START;
            n_key_pos   = '0;
            n_key_mis   = 1'b0;
            n_acc       = '0;
            n_neg       = 1'b0;
            n_has_digit = 1'b0;
        end
        if (do_fresh) begin
            n_found  = 1'b0;
            n_len    = '0;
            n_remain = '0;
        end
        if (go_payload) begin
            n_phase  = PH_PAYLOAD;
            n_remain = r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RST;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LINE_START;
            r_key_pos   <= '0;
            r_key_mis   <= 1'b0;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_has_digit <= 1'b0;
            r_found     <= 1'b0;
            r_len       <= '0;
            r_remain    <= '0;
        end else if (pop) begin
            r_phase     <= n_phase;
            r_key_pos   <= n_key_pos;
            r_key_mis   <= n_key_mis;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_has_digit <= n_has_digit;
            r_found     <= n_found;
            r_len       <= n_len;
            r_remain    <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && emit) begin
            r_out_byte   <= e_byte;
            r_out_status <= e_status;
            r_out_last   <= e_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

endmodule

@@ hw/rtl/content_length_deframer_top.sv @@
// top level of the content-length deframer: front, queue and back stages
// depends on cld_pkg, cld_front, cld_queue, cld_back
//
//  channel   dir  handshake                      carries
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata byte, tuser end of input
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata byte, tuser status, tlast
//  cfg       in   i_cfg_wr_en                    i_cfg_wr_data max length
//
// one word accepted per clock, the back-stage parser handles one word a cycle, both
// while output is not stalled; results pass front register, queue, output register
// reset is synchronous, active low; max length returns to 2147483647
// a stalled output holds in its register while the queue soaks up two words

module content_length_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    output logic        m_axis_tlast,
    input  logic        i_cfg_wr_en,
    input  logic [30:0] i_cfg_wr_data
);
    import cld_pkg::*;

    logic  front_valid;
    logic  front_ready;
    t_item front_item;
    logic  back_valid;
    logic  back_ready;
    t_item back_item;

    cld_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_eoi   (s_axis_tuser[0]),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_item  (front_item)
    );

    cld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_item  (front_item),
        .o_valid (back_valid),
        .i_ready (back_ready),
        .o_item  (back_item)
    );

    cld_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (back_valid),
        .o_ready       (back_ready),
        .i_item        (back_item),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_byte    (m_axis_tdata),
        .o_out_status  (m_axis_tuser),
        .o_out_last    (m_axis_tlast)
    );

endmodule

@@ hw/rtl/cld_checker.sv @@
// port-level checks for the content-length deframer, bound to the top level
// depends on cld_pkg (status codes) and content_length_deframer_top

module cld_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import cld_pkg::*;

    // no result straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    // the input side is open as soon as reset is released
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready right after reset");

    // every error or empty message closes the frame with a zero byte
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_PAYLOAD)) |->
            (m_axis_tlast && (m_axis_tdata == 8'h00)))
        else $error("status word without last or with a data byte");

    // only the defined status codes appear
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_PAYLOAD || m_axis_tuser == ST_EMPTY ||
                           m_axis_tuser == ST_INVALID || m_axis_tuser == ST_RANGE ||
                           m_axis_tuser == ST_MISSING || m_axis_tuser == ST_TRUNC))
        else $error("undefined status code");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
             $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind content_length_deframer_top cld_checker u_cld_checker (.*);

@@ tb/cld_frame_check.sv @@
// result checker for the content-length deframer: tracks header parsing per accepted
// input word, predicts each output word and compares it with what the block returns
// depends on cld_pkg for t_status and t_phase

module cld_frame_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,      // [7:0] data_byte
    input  logic [0:0]  i_s_tuser,      // [0] end_of_input
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,      // [7:0] payload_byte
    input  logic [2:0]  i_m_tuser,      // [2:0] status
    input  logic        i_m_tlast,
    input  logic        i_cfg_wr_en,
    input  logic [30:0] i_cfg_wr_data,
    output int          o_fail_count,
    output int          o_pending
);

    import cld_pkg::*;

    localparam int              NAME_LEN  = 14;
    localparam logic [8*14-1:0] NAME_TEXT = "Content-Length";
    localparam logic [7:0]      A_LF      = 8'h0A;
    localparam logic [7:0]      A_CR      = 8'h0D;
    localparam logic [7:0]      A_SPACE   = 8'h20;
    localparam logic [7:0]      A_COLON   = 8'h3A;
    localparam logic [7:0]      A_PLUS    = 8'h2B;
    localparam logic [7:0]      A_MINUS   = 8'h2D;
    localparam logic [7:0]      A_ZERO    = 8'h30;
    localparam logic [7:0]      A_NINE    = 8'h39;
    localparam logic [31:0]     MAG_SAT   = 32'h8000_0000;

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
        logic       last;
    } t_out_word;

    t_out_word   predicted_words[$];
    int          fail_count;

    t_phase      ph;
    logic [3:0]  key_pos;
    logic        key_bad;
    logic [31:0] acc;
    logic        neg;
    logic        seen_digit;
    logic        len_known;
    logic [30:0] len_val;
    logic [30:0] left;
    logic [30:0] max_len;

    function automatic void new_line();
        ph         = PH_LINE_START;
        key_pos    = '0;
        key_bad    = 1'b0;
        acc        = '0;
        neg        = 1'b0;
        seen_digit = 1'b0;
    endfunction

    function automatic void new_block();
        new_line();
        len_known = 1'b0;
        len_val   = '0;
        left      = '0;
    endfunction

    function automatic void expect_word(logic [7:0] d, t_status st, logic l);
        t_out_word w;
        w.data   = d;
        w.status = st;
        w.last   = l;
        predicted_words.push_back(w);
    endfunction

    function automatic bit in_value();
        return ph == PH_SIGN || ph == PH_DIGITS || ph == PH_VALUE_DONE;
    endfunction

    // ST_PAYLOAD here means the value was taken
    function automatic t_status close_value();
        if (!seen_digit)
            return ST_INVALID;
        if ((neg && acc != 0) || acc > {1'b0, max_len})
            return ST_RANGE;
        len_known = 1'b1;
        len_val   = acc[30:0];
        return ST_PAYLOAD;
    endfunction

    // magnitude sticks at 2^31 once it passes the 31-bit range
    function automatic void add_digit(logic [3:0] d);
        logic [63:0] v;
        seen_digit = 1'b1;
        if (acc >= MAG_SAT)
            return;
        v   = {32'd0, acc} * 64'd10 + {60'd0, d};
        acc = (v > 64'h7FFF_FFFF) ? MAG_SAT : v[31:0];
    endfunction

    function automatic void key_step(logic [7:0] c);
        if (c == A_COLON) begin
            ph = (!key_bad && key_pos == NAME_LEN) ? PH_WS : PH_SKIP;
            return;
        end
        ph = PH_KEY;
        if (key_pos < NAME_LEN && c == NAME_TEXT[8*(NAME_LEN-1-key_pos) +: 8])
            key_pos = key_pos + 1'b1;
        else
            key_bad = 1'b1;
    endfunction

    // end of a header block; returns 1 when it produced a word
    function automatic bit close_block();
        if (!len_known) begin
            new_block();
            expect_word(8'd0, ST_MISSING, 1'b1);
            return 1'b1;
        end
        if (len_val == 0) begin
            new_block();
            expect_word(8'd0, ST_EMPTY, 1'b1);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void parse_word(logic [7:0] c, logic eoi);
        t_status st;
        logic    is_digit;
        logic    fin;
        is_digit = (c >= A_ZERO && c <= A_NINE);
        if (eoi) begin
            if (ph == PH_PAYLOAD) begin
                new_block();
                expect_word(8'd0, ST_TRUNC, 1'b1);
                return;
            end
            // a partial line is closed first and its error wins
            st = ST_PAYLOAD;
            if (in_value())
                st = close_value();
            if (st != ST_PAYLOAD) begin
                new_block();
                expect_word(8'd0, st, 1'b1);
                return;
            end
            if (!close_block()) begin
                new_block();
                expect_word(8'd0, ST_TRUNC, 1'b1);
            end
            return;
        end
        if (ph == PH_PAYLOAD) begin
            fin  = (left <= 1);
            left = left - 1'b1;
            if (fin)
                new_block();
            expect_word(c, ST_PAYLOAD, fin);
            return;
        end
        if (c == A_LF) begin
            if (ph == PH_LINE_START || ph == PH_LINE_CR) begin
                if (!close_block()) begin
                    new_line();
                    left = len_val;
                    ph   = PH_PAYLOAD;
                end
                return;
            end
            if (in_value()) begin
                st = close_value();
                if (st != ST_PAYLOAD) begin
                    new_block();
                    expect_word(8'd0, st, 1'b1);
                    return;
                end
            end
            new_line();
            return;
        end
        case (ph)
            PH_LINE_START: begin
                if (c == A_CR) begin
                    key_bad = 1'b1;
                    ph      = PH_LINE_CR;
                end else begin
                    key_step(c);
                end
            end
            PH_LINE_CR, PH_KEY: key_step(c);
            PH_WS: begin
                if (!(c == A_SPACE || (c >= 8'd9 && c <= 8'd13))) begin
                    if (c == A_PLUS || c == A_MINUS) begin
                        neg = (c == A_MINUS);
                        ph  = PH_SIGN;
                    end else if (is_digit) begin
                        add_digit(c[3:0]);
                        ph = PH_DIGITS;
                    end else begin
                        ph = PH_VALUE_DONE;
                    end
                end
            end
            PH_SIGN, PH_DIGITS: begin
                // low nibble of an ascii digit is its value
                if (is_digit) begin
                    add_digit(c[3:0]);
                    ph = PH_DIGITS;
                end else begin
                    ph = PH_VALUE_DONE;
                end
            end
            PH_VALUE_DONE, PH_SKIP: ;
            default: new_line();
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            max_len = 31'h7FFF_FFFF;
            new_block();
            predicted_words.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_wr_en)
                max_len = i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready)
                parse_word(i_s_tdata, i_s_tuser[0]);
            if (i_m_tvalid && i_m_tready) begin
                if (predicted_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word data %02h status %0d last %0b",
                                              i_m_tdata, i_m_tuser, i_m_tlast));
                end else begin
                    want = predicted_words.pop_front();
                    if (i_m_tdata !== want.data)
                        report_mismatch($sformatf("data %02h, wanted %02h",
                                                  i_m_tdata, want.data));
                    if (i_m_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  i_m_tuser, want.status));
                    if (i_m_tlast !== want.last)
                        report_mismatch($sformatf("last %0b, wanted %0b",
                                                  i_m_tlast, want.last));
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= predicted_words.size();
    end

endmodule

@@ tb/testbench.sv @@
// top of the content-length deframer test: clock, reset, byte stream stimulus with
// random gaps and output stalls, max length changes between phases, and the verdict
// depends on content_length_deframer_top and cld_frame_check

module testbench;

    localparam logic [7:0] A_LF        = 8'h0A;
    localparam logic [7:0] A_CR        = 8'h0D;
    localparam logic [7:0] A_TAB       = 8'h09;
    localparam logic [7:0] A_VT        = 8'h0B;
    localparam logic [7:0] A_FF        = 8'h0C;
    localparam logic [7:0] A_SPACE     = 8'h20;
    localparam int         DRAIN_WAIT  = 8;
    localparam int         QUIET_LIMIT = 1000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] data_byte
    logic [0:0]  s_axis_tuser;     // [0] end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;     // [7:0] payload_byte
    logic [2:0]  m_axis_tuser;     // [2:0] status
    logic        m_axis_tlast;
    logic        i_cfg_wr_en;
    logic [30:0] i_cfg_wr_data;

    int          fail_total;
    int          pending_words;
    int          burst_left;
    int          quiet_cycles;
    logic [8:0]  tx_words[$];      // [8] end of input, [7:0] byte

    content_length_deframer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    cld_frame_check frame_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .i_m_tlast     (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_fail_count  (fail_total),
        .o_pending     (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // output back-pressure: long ready runs, short stalls, now and then a long one
    initial begin : ready_gen
        int hold;
        int roll;
        hold          = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    m_axis_tready <= 1'b1;
                    hold = $urandom_range(1, 30);
                end else if (roll < 92) begin
                    m_axis_tready <= 1'b0;
                    hold = $urandom_range(0, 2);
                end else begin
                    m_axis_tready <= 1'b0;
                    hold = $urandom_range(8, 60);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            burst_left = $urandom_range(16, 64);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void put_byte(logic [7:0] b);
        tx_words.push_back({1'b0, b});
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            tx_words.push_back({1'b0, s[i]});
    endfunction

    // byte field is random: the block must ignore it on end of input
    function automatic void put_eoi();
        tx_words.push_back({1'b1, 8'($urandom)});
    endfunction

    function automatic void put_line(string s, bit crlf);
        put_text(s);
        if (crlf)
            put_byte(A_CR);
        put_byte(A_LF);
    endfunction

    function automatic void put_eol();
        if ($urandom_range(0, 1))
            put_byte(A_CR);
        put_byte(A_LF);
    endfunction

    function automatic void put_other_line();
        case ($urandom_range(0, 4))
            0: put_text("Content-Type: text/plain");
            1: put_text("Host: x");
            2: put_text("Content-Lengt: 3");
            3: put_text("Content-Length : 2");
            default: put_text("X-Length: 7");
        endcase
        put_eol();
    endfunction

    // a length line with random blanks, sign, leading zeros and trailing junk
    function automatic void put_length_line(int n);
        int   r;
        logic [7:0] blank;
        put_text("Content-Length:");
        repeat ($urandom_range(0, 2)) begin
            r = $urandom_range(0, 4);
            blank = (r == 0) ? A_TAB : (r == 1) ? A_VT : (r == 2) ? A_FF :
                    (r == 3) ? A_CR : A_SPACE;
            put_byte(blank);
        end
        if ($urandom_range(0, 5) == 0)
            put_text("+");
        if ($urandom_range(0, 5) == 0)
            put_text("00");
        put_text($sformatf("%0d", n));
        if ($urandom_range(0, 5) == 0)
            put_text(" ;x");
        put_eol();
    endfunction

    function automatic void put_random_message();
        int    kind;
        int    plen;
        int    n;
        int    r;
        string hdr;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
            put_other_line();
        if (kind < 70) begin
            r = $urandom_range(0, 99);
            plen = (r < 80) ? $urandom_range(0, 6) :
                   (r < 97) ? $urandom_range(7, 20) : $urandom_range(21, 60);
            if ($urandom_range(0, 4) == 0)
                put_length_line($urandom_range(0, 50));
            put_length_line(plen);
            if ($urandom_range(0, 5) == 0)
                put_other_line();
            put_eol();
            if (plen > 0 && $urandom_range(0, 14) == 0) begin
                n = $urandom_range(0, plen - 1);
                repeat (n) put_byte(8'($urandom));
                put_eoi();
            end else begin
                repeat (plen) put_byte(8'($urandom));
            end
        end else if (kind < 82) begin
            case ($urandom_range(0, 6))
                0: hdr = $sformatf("Content-Length: -%0d", $urandom_range(1, 99));
                1: hdr = "Content-Length: +";
                2: hdr = "Content-Length: abc";
                3: hdr = "Content-Length: 98765432109876";
                4: hdr = "Content-Length:   ";
                5: hdr = "Content-Length: -0";
                default: begin
                    hdr = "Content-Length: 3";
                    hdr[$urandom_range(0, 13)] = 8'($urandom_range(33, 126));
                end
            endcase
            put_text(hdr);
            put_eol();
            if ($urandom_range(0, 1))
                put_eol();
        end else if (kind < 92) begin
            repeat ($urandom_range(1, 12)) begin
                r = $urandom_range(0, 9);
                put_byte((r < 2) ? A_LF : (r < 3) ? A_CR : 8'($urandom));
            end
        end else begin
            // stream ends inside a header line
            hdr = $sformatf("Content-Length: %0d", $urandom_range(0, 30));
            put_text(hdr.substr(0, $urandom_range(0, hdr.len() - 1)));
            put_eoi();
        end
    endfunction

    task automatic send_word(logic [7:0] b, logic eoi);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= eoi;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic flush_words();
        logic [8:0] w;
        while (tx_words.size() > 0) begin
            w = tx_words.pop_front();
            send_word(w[7:0], w[8]);
        end
    endtask

    // wait until every expected word is out and the pipeline has drained
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_max_length(logic [30:0] v);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_run(int budget);
        while (budget > 0) begin
            put_random_message();
            budget -= tx_words.size();
            flush_words();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 31'd0;
        burst_left    = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed cases at the reset max length
        put_line("Content-Length: 3", 1'b1);
        put_line("", 1'b1);
        put_text("abc");
        put_line("Content-Length: 2", 1'b0);
        put_line("", 1'b0);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_line("Content-Length: 0", 1'b0);
        put_line("", 1'b0);
        put_line("", 1'b0);                         // no length at all
        put_line("", 1'b1);                         // cr-only line ends the block
        put_line("Content-Length: x", 1'b0);        // no digits
        put_line("Content-Length: +", 1'b0);        // sign with no digits
        put_line("Content-Length:", 1'b0);          // empty value is ignored
        put_line("", 1'b0);
        put_line("Content-Length: -0", 1'b1);
        put_line("", 1'b1);
        put_line("Content-Length: -7", 1'b0);
        put_line("Content-Length: 99999999999", 1'b0);
        put_line("Content-Length: 9", 1'b0);        // overridden by the next line
        put_line("Content-Length: 2", 1'b0);
        put_line("", 1'b0);
        put_text("xy");
        put_line("Content-Type: text", 1'b0);
        put_text("Content-Length:");
        put_byte(A_TAB);
        put_byte(A_VT);
        put_byte(A_FF);
        put_line(" +01 junk", 1'b1);
        put_line("", 1'b1);
        put_text("Z");
        put_line("content-length: 4", 1'b0);
        put_line("Content-Lengthx: 1", 1'b0);
        put_byte(A_CR);
        put_line("X: 1", 1'b0);
        put_line("", 1'b0);
        put_eoi();                                  // end of input on a fresh block
        put_line("Content-Length: 4", 1'b0);
        put_line("", 1'b0);
        put_text("ab");
        put_eoi();
        put_text("Content-Length: 12");
        put_eoi();
        put_text("Content-Length: -");
        put_eoi();
        put_line("Content-Length: 0", 1'b0);
        put_eoi();
        put_line("Content-Length: 2147483647", 1'b0);
        put_eoi();
        flush_words();

        write_max_length(31'd5);
        put_line("Content-Length: 6", 1'b0);
        put_line("Content-Length: 5", 1'b0);
        put_line("", 1'b0);
        put_text("12345");
        flush_words();

        write_max_length(31'd0);
        put_line("Content-Length: 1", 1'b0);
        put_line("Content-Length: 0", 1'b0);
        put_line("", 1'b0);
        flush_words();

        write_max_length(31'h7FFF_FFFF);
        random_run(10);
        write_max_length(31'($urandom_range(2, 12)));
        random_run(10);
        write_max_length(31'd0);
        random_run(10);
        write_max_length(31'($urandom_range(13, 300)));
        random_run(10);

        wait_idle();
        if (fail_total == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
